// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the compositor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lac_pkg.sv -----
// Package: types, constants and helper functions of the LED layer compositor.
`default_nettype none

package lac_pkg;

  localparam int IdxW        = 9;
  localparam int Depth       = 1 << IdxW;
  localparam int ChanW       = 8;
  localparam int RgbW        = 3 * ChanW;
  localparam int RgbaW       = 4 * ChanW;
  localparam int SumW        = 2 * ChanW;
  localparam int FullAlpha   = 255;
  localparam int PanelRows   = 8;
  localparam int PanelRowsLg = 3;
  localparam int Columns     = 32;
  localparam int PerPanel    = PanelRows * Columns;
  localparam int MaxPanel    = (Depth - 1) / PerPanel;
  localparam int EnW         = 3;

  typedef enum logic {
    OpWrite  = 1'b0,
    OpRender = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    LayerBase   = 2'd0,
    LayerEffect = 2'd1,
    LayerOsd    = 2'd2
  } layer_e;

  // Control of one layer store for one cycle.
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    logic            re;
    logic [IdxW-1:0] raddr;
  } mem_ctrl_t;

  // Serpentine chain position to matrix index.
  function automatic logic [IdxW-1:0] chain_to_matrix(logic [IdxW-1:0] pos);
    logic [IdxW-1:0]        panel;
    logic [31:0]            in_panel;
    logic [IdxW-1:0]        x;
    logic [PanelRowsLg-1:0] y;
    logic [31:0]            row;
    logic [31:0]            lin;
    panel = '0;
    // Thresholds rise with k, so the last hit is the panel number.
    for (int k = 1; k <= MaxPanel; k++) begin
      if ({{(32-IdxW){1'b0}}, pos} >= 32'(k * PerPanel)) begin
        panel = IdxW'(k);
      end
    end
    in_panel = {{(32-IdxW){1'b0}}, pos} - 32'(panel) * 32'(PerPanel);
    x        = IdxW'(in_panel >> PanelRowsLg);
    y        = in_panel[PanelRowsLg-1:0];
    // Odd columns run bottom to top.
    if (x[0]) begin
      y = PanelRowsLg'(PanelRows - 1) - y;
    end
    row = 32'(panel) * 32'(PanelRows) + 32'(y);
    lin = row * 32'(Columns) + 32'(x);
    return lin[IdxW-1:0];
  endfunction

  // floor(x / 255), exact for x up to 255 * 255.
  function automatic logic [ChanW-1:0] div255(logic [SumW-1:0] x);
    logic [SumW:0] t;
    t = {1'b0, x} + {1'b0, (x >> ChanW)} + {{SumW{1'b0}}, 1'b1};
    return t[SumW-1:ChanW];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/led_layer_alpha_compositor_core.sv -----
// LED layer compositor: layer stores, address mapping and blend pipeline.
//
// Usage:
//   Requests arrive on in_valid_i/in_ready_o. op_i = write stores one pixel
//   into the layer chosen by layer_sel_i at pixel_index_i and gives no result;
//   a select of 3 is dropped. op_i = render maps led_position_i through the
//   serpentine panel layout, reads all three layers at that index and returns
//   the composited colour on out_valid_o/out_ready_i, tagged with led_number_o.
//   The user writes layer_enable through cfg_we_i/cfg_wdata_i only while the
//   block idles; the block itself does not enforce this. A render passes the
//   input register, memory read, effect blend, osd blend and output register.
//   Throughput: one request per cycle unless stalled, writes and renders mixed
//   freely; a write is committed before any later render reads the stores.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_ready_o drops until the result is taken.
//   Reset clears the pipeline valids and layer_enable; store contents stay
//   undefined until written, and there is no clearing pass.
`default_nettype none

module led_layer_alpha_compositor_core (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire                          op_i,
  input  wire  [1:0]                   layer_sel_i,
  input  wire  [lac_pkg::IdxW-1:0]     pixel_index_i,
  input  wire  [lac_pkg::ChanW-1:0]    pixel_red_i,
  input  wire  [lac_pkg::ChanW-1:0]    pixel_green_i,
  input  wire  [lac_pkg::ChanW-1:0]    pixel_blue_i,
  input  wire  [lac_pkg::ChanW-1:0]    pixel_alpha_i,
  input  wire  [lac_pkg::IdxW-1:0]     led_position_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [lac_pkg::IdxW-1:0]     led_number_o,
  output logic [lac_pkg::ChanW-1:0]    led_red_o,
  output logic [lac_pkg::ChanW-1:0]    led_green_o,
  output logic [lac_pkg::ChanW-1:0]    led_blue_o,
  input  wire                          cfg_we_i,
  input  wire  [lac_pkg::EnW-1:0]      cfg_wdata_i
);

  `include "assert_macros.svh"

  logic                        adv;
  logic [lac_pkg::EnW-1:0]     enable_q;

  // Input stage
  logic                        v0_q;
  lac_pkg::op_e                op0_q;
  logic [1:0]                  sel0_q;
  logic [lac_pkg::IdxW-1:0]    widx0_q;
  logic [lac_pkg::IdxW-1:0]    midx0_q;
  logic [lac_pkg::IdxW-1:0]    pos0_q;
  logic [lac_pkg::RgbaW-1:0]   rgba0_q;

  // Later stages
  logic                        v1_q, v2_q, v3_q;
  logic [lac_pkg::IdxW-1:0]    pos1_q, pos2_q, pos3_q;
  logic [lac_pkg::RgbaW-1:0]   osd2_q;

  logic                        out_valid_q;
  logic [lac_pkg::IdxW-1:0]    led_number_q;
  logic [lac_pkg::RgbW-1:0]    led_rgb_q;

  lac_pkg::mem_ctrl_t          base_ctrl, eff_ctrl, osd_ctrl;
  logic [lac_pkg::RgbW-1:0]    base_rd;
  logic [lac_pkg::RgbaW-1:0]   eff_rd;
  logic [lac_pkg::RgbaW-1:0]   osd_rd;
  logic [lac_pkg::RgbW-1:0]    color0, color1, color2;
  logic                        wr_item;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
    end else if (cfg_we_i) begin
      enable_q <= cfg_wdata_i;
    end
  end

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v0_q        <= in_valid_i;
      v1_q        <= v0_q && (op0_q == lac_pkg::OpRender);
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (in_valid_i) begin
        op0_q   <= lac_pkg::op_e'(op_i);
        sel0_q  <= layer_sel_i;
        widx0_q <= pixel_index_i;
        midx0_q <= lac_pkg::chain_to_matrix(led_position_i);
        pos0_q  <= led_position_i;
        rgba0_q <= {pixel_alpha_i, pixel_red_i, pixel_green_i, pixel_blue_i};
      end
      pos1_q       <= pos0_q;
      pos2_q       <= pos1_q;
      osd2_q       <= osd_rd;
      pos3_q       <= pos2_q;
      led_number_q <= pos3_q;
      led_rgb_q    <= color2;
    end
  end

  // Store access: writes commit as the request leaves the input stage
  assign wr_item = adv && v0_q && (op0_q == lac_pkg::OpWrite);

  always_comb begin
    base_ctrl.we    = wr_item && (sel0_q == lac_pkg::LayerBase);
    base_ctrl.waddr = widx0_q;
    base_ctrl.re    = adv;
    base_ctrl.raddr = midx0_q;
    eff_ctrl        = base_ctrl;
    eff_ctrl.we     = wr_item && (sel0_q == lac_pkg::LayerEffect);
    osd_ctrl        = base_ctrl;
    osd_ctrl.we     = wr_item && (sel0_q == lac_pkg::LayerOsd);
  end

  lac_layer_mem #(
    .DATA_W (lac_pkg::RgbW)
  ) u_base_mem (
    .clk_i   (clk_i),
    .ctrl_i  (base_ctrl),
    .wdata_i (rgba0_q[lac_pkg::RgbW-1:0]),
    .rdata_o (base_rd)
  );

  lac_layer_mem #(
    .DATA_W (lac_pkg::RgbaW)
  ) u_eff_mem (
    .clk_i   (clk_i),
    .ctrl_i  (eff_ctrl),
    .wdata_i (rgba0_q),
    .rdata_o (eff_rd)
  );

  lac_layer_mem #(
    .DATA_W (lac_pkg::RgbaW)
  ) u_osd_mem (
    .clk_i   (clk_i),
    .ctrl_i  (osd_ctrl),
    .wdata_i (rgba0_q),
    .rdata_o (osd_rd)
  );

  assign color0 = enable_q[0] ? base_rd : '0;

  lac_blend u_eff_blend (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .layer_on_i (enable_q[1]),
    .under_i    (color0),
    .over_i     (eff_rd),
    .color_o    (color1)
  );

  lac_blend u_osd_blend (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .layer_on_i (enable_q[2]),
    .under_i    (color1),
    .over_i     (osd2_q),
    .color_o    (color2)
  );

  assign out_valid_o  = out_valid_q;
  assign led_number_o = led_number_q;
  assign led_red_o    = led_rgb_q[2*lac_pkg::ChanW +: lac_pkg::ChanW];
  assign led_green_o  = led_rgb_q[lac_pkg::ChanW +: lac_pkg::ChanW];
  assign led_blue_o   = led_rgb_q[0 +: lac_pkg::ChanW];

  `ASSERT_NEXT(a_write_silent, clk_i, rst_ni, v0_q && adv && (op0_q == lac_pkg::OpWrite), !v1_q, "write request entered the render pipeline")
  `ASSERT_NEXT(a_render_moves, clk_i, rst_ni, v1_q && adv, v2_q, "render lost after memory read")
  `ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, v1_q && !adv, v1_q && $stable(pos1_q), "read stage changed during stall")
  `ASSERT_IMPLIES(a_out_source, clk_i, rst_ni, $rose(out_valid_q), $past(v3_q), "result without a render behind it")

endmodule

`default_nettype wire

// ----- rtl/lac_layer_mem.sv -----
// One layer store: synchronous memory, one write and one registered read port.
`default_nettype none

module lac_layer_mem #(
  parameter int DATA_W = lac_pkg::RgbaW
) (
  input  wire                    clk_i,
  input  lac_pkg::mem_ctrl_t     ctrl_i,
  input  wire  [DATA_W-1:0]      wdata_i,
  output logic [DATA_W-1:0]      rdata_o
);

  logic [DATA_W-1:0] mem [lac_pkg::Depth];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem[ctrl_i.waddr] <= wdata_i;
    end
    if (ctrl_i.re) begin
      rdata_q <= mem[ctrl_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/lac_blend.sv -----
// One overlay blend stage: registered products, then divide by 255.
`default_nettype none

module lac_blend (
  input  wire                          clk_i,
  input  wire                          adv_i,
  input  wire                          layer_on_i,
  input  wire  [lac_pkg::RgbW-1:0]     under_i,
  input  wire  [lac_pkg::RgbaW-1:0]    over_i,
  output logic [lac_pkg::RgbW-1:0]     color_o
);

  logic [lac_pkg::SumW-1:0]  sum_d [3];
  logic [lac_pkg::SumW-1:0]  sum_q [3];
  logic [lac_pkg::RgbW-1:0]  under_q;
  logic                      on_q;
  logic [lac_pkg::ChanW-1:0] alpha;
  logic [lac_pkg::ChanW-1:0] alpha_n;

  assign alpha   = over_i[lac_pkg::RgbaW-1 -: lac_pkg::ChanW];
  assign alpha_n = lac_pkg::ChanW'(lac_pkg::FullAlpha) - alpha;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_d[c] = lac_pkg::SumW'(under_i[c*lac_pkg::ChanW +: lac_pkg::ChanW]) *
                 lac_pkg::SumW'(alpha_n) +
                 lac_pkg::SumW'(over_i[c*lac_pkg::ChanW +: lac_pkg::ChanW]) *
                 lac_pkg::SumW'(alpha);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sum_q   <= sum_d;
      under_q <= under_i;
      on_q    <= layer_on_i;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      color_o[c*lac_pkg::ChanW +: lac_pkg::ChanW] =
        on_q ? lac_pkg::div255(sum_q[c])
             : under_q[c*lac_pkg::ChanW +: lac_pkg::ChanW];
    end
  end

endmodule

`default_nettype wire
